// ----- hw/rtl/rhcc_pkg.sv -----
// rhcc_pkg: shared widths, register indexes, reset values, class codes and the
// divider request type of the rgb hue color classifier
// no dependencies
`timescale 1ns / 1ps

package rhcc_pkg;

	localparam int CountW = 16;
	localparam int HueW   = 16;
	localparam int ClassW = 3;
	localparam int RegW   = 16;
	localparam int IndexW = 8;

	// register file
	localparam int NumRegs = 8;
	localparam int RegSelW = $clog2(NumRegs);

	localparam logic [RegSelW-1:0] RegWhiteOffset  = RegSelW'(0);
	localparam logic [RegSelW-1:0] RegBlackOffset  = RegSelW'(1);
	localparam logic [RegSelW-1:0] RegRedHueMin    = RegSelW'(2);
	localparam logic [RegSelW-1:0] RegMagentaHueMin = RegSelW'(3);
	localparam logic [RegSelW-1:0] RegBlueHueMin   = RegSelW'(4);
	localparam logic [RegSelW-1:0] RegCyanHueMin   = RegSelW'(5);
	localparam logic [RegSelW-1:0] RegGreenHueMin  = RegSelW'(6);
	localparam logic [RegSelW-1:0] RegYellowHueMin = RegSelW'(7);

	localparam logic [RegW-1:0] RegReset [NumRegs] = '{
		16'd500, 16'd500, 16'd60075, 16'd50972,
		16'd36409, 16'd29127, 16'd14563, 16'd5461
	};

	// running brightness extremes after reset
	localparam logic [CountW-1:0] LowestReset  = 16'd65000;
	localparam logic [CountW-1:0] HighestReset = 16'd0;

	// color class codes
	localparam logic [ClassW-1:0] ClassWhite   = 3'd0;
	localparam logic [ClassW-1:0] ClassBlack   = 3'd1;
	localparam logic [ClassW-1:0] ClassRed     = 3'd2;
	localparam logic [ClassW-1:0] ClassMagenta = 3'd3;
	localparam logic [ClassW-1:0] ClassBlue    = 3'd4;
	localparam logic [ClassW-1:0] ClassCyan    = 3'd5;
	localparam logic [ClassW-1:0] ClassGreen   = 3'd6;
	localparam logic [ClassW-1:0] ClassYellow  = 3'd7;

	// divider: numerator and divisor hold up to six times a count
	localparam int DivW     = CountW + 3;
	localparam int DivSteps = HueW + 1;
	localparam int DivCntW  = $clog2(DivSteps);

	// sector of the hue circle: base = 2 * half, numerator added or subtracted
	typedef struct packed {
		logic [1:0]        half;
		logic              minus;
		logic [CountW-1:0] n;
		logic [CountW-1:0] d;
	} div_req_t;

endpackage

// ----- hw/rtl/rhcc_if.sv -----
// rhcc_if: valid/ready channels of the rgb hue color classifier
// depends on rhcc_pkg
`timescale 1ns / 1ps

// sample channel: raw sensor counts
interface rhcc_in_if;
	logic                         valid;
	logic                         ready;
	logic [rhcc_pkg::CountW-1:0]  red_count;
	logic [rhcc_pkg::CountW-1:0]  green_count;
	logic [rhcc_pkg::CountW-1:0]  blue_count;
	logic [rhcc_pkg::CountW-1:0]  clear_count;

	modport source (output valid, red_count, green_count, blue_count, clear_count,
		input ready);
	modport sink (input valid, red_count, green_count, blue_count, clear_count,
		output ready);
endinterface

// result channel: class and hue
interface rhcc_out_if;
	logic                         valid;
	logic                         ready;
	logic [rhcc_pkg::ClassW-1:0]  color_class;
	logic [rhcc_pkg::HueW-1:0]    hue_value;
	logic                         hue_undefined;

	modport source (output valid, color_class, hue_value, hue_undefined, input ready);
	modport sink (input valid, color_class, hue_value, hue_undefined, output ready);
endinterface

// ----- hw/rtl/rhcc_div.sv -----
// rhcc_div: bit-serial restoring divider that forms the hue as a fraction of a turn
// depends on rhcc_pkg
`timescale 1ns / 1ps

module rhcc_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  rhcc_pkg::div_req_t          req,
	output logic                        done,
	output logic [rhcc_pkg::HueW-1:0]   quot
);

	logic [rhcc_pkg::DivW-1:0]    d_ext;
	logic [rhcc_pkg::DivW-1:0]    n_ext;
	logic [rhcc_pkg::DivW-1:0]    d2;
	logic [rhcc_pkg::DivW-1:0]    d4;
	logic [rhcc_pkg::DivW-1:0]    base_d;
	logic [rhcc_pkg::DivW-1:0]    num;
	logic [rhcc_pkg::DivW-1:0]    den;
	logic [rhcc_pkg::DivW:0]      trial;
	logic [rhcc_pkg::DivW:0]      diff;
	logic                         ge;
	logic                         first;

	logic [rhcc_pkg::DivW-1:0]    rem_q;
	logic [rhcc_pkg::DivW-1:0]    den_q;
	logic [rhcc_pkg::HueW-1:0]    quot_q;
	logic [rhcc_pkg::DivCntW-1:0] cnt_q;
	logic                         busy_q;
	logic                         done_q;

	// numerator base*D +/- N and divisor 6*D from shifts and adds
	always_comb begin
		d_ext = rhcc_pkg::DivW'(req.d);
		n_ext = rhcc_pkg::DivW'(req.n);
		d2    = d_ext << 1;
		d4    = d_ext << 2;
		den   = d4 + d2;
		case (req.half)
			2'd0: base_d = '0;
			2'd1: base_d = d2;
			2'd2: base_d = d4;
			2'd3: base_d = den;
			default: base_d = '0;
		endcase
		num = req.minus ? (base_d - n_ext) : (base_d + n_ext);
	end

	// one quotient bit per step; the first step holds the whole-turn bit
	always_comb begin
		first = (cnt_q == rhcc_pkg::DivCntW'(rhcc_pkg::DivSteps - 1));
		trial = first ? {1'b0, rem_q} : {rem_q, 1'b0};
		ge    = (trial >= {1'b0, den_q});
		diff  = trial - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			rem_q  <= num;
			den_q  <= den;
			cnt_q  <= rhcc_pkg::DivCntW'(rhcc_pkg::DivSteps - 1);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			rem_q  <= ge ? diff[rhcc_pkg::DivW-1:0] : trial[rhcc_pkg::DivW-1:0];
			// the whole-turn bit falls off the top, giving the wrap to zero
			quot_q <= {quot_q[rhcc_pkg::HueW-2:0], ge};
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

// ----- hw/rtl/rgb_hue_color_classifier.sv -----
// Preucil hue color classifier. Each accepted sample beat (red, green, blue and clear
// counts) yields one result beat: a color class, the hue as a 16-bit fraction of a
// turn, and a flag for equal channels, where the hue reads as zero. The clear count
// folds into a running minimum and maximum used for the white and black tests. Each
// sample passes through a sector setup state, a divider load state, the bit-serial
// divider that produces one quotient bit per cycle until it flags done, and a
// classification state. The next sample is taken in the cycle after the result
// loads. Samples are handled one at a time; a waiting result does not block the
// next sample, which then holds in classification until the result register
// frees. Registers are written through wr_en / wr_index / wr_data; the user must
// write them only while the block is idle, which the block itself does not enforce;
// indexes above 7 are ignored.
// depends on rhcc_pkg, rhcc_if, rhcc_div
`timescale 1ns / 1ps

module rgb_hue_color_classifier (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_en,
	input  logic [rhcc_pkg::IndexW-1:0] wr_index,
	input  logic [rhcc_pkg::RegW-1:0]   wr_data,
	rhcc_in_if.sink                     sample,
	rhcc_out_if.source                  result
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_LOAD,
		ST_DIV,
		ST_FIN
	} state_t;

	state_t                         state_q;

	logic [rhcc_pkg::RegW-1:0]      cfg_q [rhcc_pkg::NumRegs];
	logic [rhcc_pkg::CountW-1:0]    r_q;
	logic [rhcc_pkg::CountW-1:0]    g_q;
	logic [rhcc_pkg::CountW-1:0]    b_q;
	logic [rhcc_pkg::CountW-1:0]    c_q;
	logic [rhcc_pkg::CountW-1:0]    low_q;
	logic [rhcc_pkg::CountW-1:0]    high_q;
	logic                           undef_q;
	rhcc_pkg::div_req_t             req_q;

	logic                           res_valid_q;
	logic [rhcc_pkg::ClassW-1:0]    res_class_q;
	logic [rhcc_pkg::HueW-1:0]      res_hue_q;
	logic                           res_undef_q;

	rhcc_pkg::div_req_t             req_nxt;
	logic                           undef_nxt;
	logic                           ge_rg, ge_gr, ge_gb, ge_bg, ge_rb, ge_br;
	logic                           div_start;
	logic                           div_done;
	logic [rhcc_pkg::HueW-1:0]      div_quot;
	logic [rhcc_pkg::HueW-1:0]      hue;
	logic [rhcc_pkg::CountW-1:0]    thr_white;
	logic [rhcc_pkg::CountW-1:0]    thr_black;
	logic [rhcc_pkg::ClassW-1:0]    cls;
	logic                           accept;
	logic                           res_free;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= rhcc_pkg::RegReset;
		end else if (wr_en && (wr_index < rhcc_pkg::IndexW'(rhcc_pkg::NumRegs))) begin
			cfg_q[wr_index[rhcc_pkg::RegSelW-1:0]] <= wr_data;
		end
	end

	// sector of the hue circle, tested in fixed order
	always_comb begin
		ge_rg = (r_q >= g_q);
		ge_gr = (g_q >= r_q);
		ge_gb = (g_q >= b_q);
		ge_bg = (b_q >= g_q);
		ge_rb = (r_q >= b_q);
		ge_br = (b_q >= r_q);
		undef_nxt = (r_q == g_q) && (g_q == b_q);
		if (ge_rg && ge_gb) begin
			req_nxt = '{half: 2'd0, minus: 1'b0, n: g_q - b_q, d: r_q - b_q};
		end else if (ge_gr && ge_rb) begin
			req_nxt = '{half: 2'd1, minus: 1'b1, n: r_q - b_q, d: g_q - b_q};
		end else if (ge_gb && ge_br) begin
			req_nxt = '{half: 2'd1, minus: 1'b0, n: b_q - r_q, d: g_q - r_q};
		end else if (ge_bg && ge_gr) begin
			req_nxt = '{half: 2'd2, minus: 1'b1, n: g_q - r_q, d: b_q - r_q};
		end else if (ge_br && ge_rg) begin
			req_nxt = '{half: 2'd2, minus: 1'b0, n: r_q - g_q, d: b_q - g_q};
		end else begin
			req_nxt = '{half: 2'd3, minus: 1'b1, n: b_q - g_q, d: r_q - g_q};
		end
	end

	assign div_start = (state_q == ST_LOAD);

	rhcc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.req    (req_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	// brightness tests first, an undefined hue as red, then hue thresholds from the top down
	always_comb begin
		hue       = undef_q ? '0 : div_quot;
		thr_white = high_q - cfg_q[rhcc_pkg::RegWhiteOffset];
		thr_black = low_q + cfg_q[rhcc_pkg::RegBlackOffset];
		if (c_q > thr_white) begin
			cls = rhcc_pkg::ClassWhite;
		end else if (c_q < thr_black) begin
			cls = rhcc_pkg::ClassBlack;
		end else if (undef_q) begin
			cls = rhcc_pkg::ClassRed;
		end else if (hue > cfg_q[rhcc_pkg::RegRedHueMin]) begin
			cls = rhcc_pkg::ClassRed;
		end else if (hue > cfg_q[rhcc_pkg::RegMagentaHueMin]) begin
			cls = rhcc_pkg::ClassMagenta;
		end else if (hue > cfg_q[rhcc_pkg::RegBlueHueMin]) begin
			cls = rhcc_pkg::ClassBlue;
		end else if (hue > cfg_q[rhcc_pkg::RegCyanHueMin]) begin
			cls = rhcc_pkg::ClassCyan;
		end else if (hue > cfg_q[rhcc_pkg::RegGreenHueMin]) begin
			cls = rhcc_pkg::ClassGreen;
		end else if (hue > cfg_q[rhcc_pkg::RegYellowHueMin]) begin
			cls = rhcc_pkg::ClassYellow;
		end else begin
			cls = rhcc_pkg::ClassRed;
		end
	end

	assign accept   = sample.valid && (state_q == ST_IDLE);
	assign res_free = !res_valid_q || result.ready;

	// sequencer, running extremes and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			low_q       <= rhcc_pkg::LowestReset;
			high_q      <= rhcc_pkg::HighestReset;
			res_valid_q <= 1'b0;
		end else begin
			// a result leaving while the next one loads stays valid
			if (res_valid_q && result.ready && (state_q != ST_FIN)) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						r_q <= sample.red_count;
						g_q <= sample.green_count;
						b_q <= sample.blue_count;
						c_q <= sample.clear_count;
						if (sample.clear_count < low_q) begin
							low_q <= sample.clear_count;
						end
						if (sample.clear_count > high_q) begin
							high_q <= sample.clear_count;
						end
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					req_q   <= req_nxt;
					undef_q <= undef_nxt;
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (res_free) begin
						res_valid_q <= 1'b1;
						res_class_q <= cls;
						res_hue_q   <= hue;
						res_undef_q <= undef_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign sample.ready         = (state_q == ST_IDLE);
	assign result.valid         = res_valid_q;
	assign result.color_class   = res_class_q;
	assign result.hue_value     = res_hue_q;
	assign result.hue_undefined = res_undef_q;

endmodule
